// ===== rtl/ghd_pkg.sv =====
// Shared types, constants and header-field selection for the gzip header deframer.
package ghd_pkg;

    localparam int HEAD_LEN    = 18;
    localparam int FIXED_LEN   = 10;
    localparam int TRAILER_LEN = 8;
    localparam int IDX_W       = 5;
    localparam int FILL_W      = 4;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    localparam logic [7:0] MAGIC0         = 8'h1f;
    localparam logic [7:0] MAGIC1         = 8'h8b;
    localparam logic [7:0] METHOD_DEFLATE = 8'h08;

    // FLG bit positions
    localparam int FLG_HCRC    = 1;
    localparam int FLG_EXTRA   = 2;
    localparam int FLG_NAME    = 3;
    localparam int FLG_COMMENT = 4;

    // header field stages
    localparam logic [2:0] STG_EXTRA   = 3'd0;
    localparam logic [2:0] STG_NAME    = 3'd1;
    localparam logic [2:0] STG_COMMENT = 3'd2;
    localparam logic [2:0] STG_HCRC    = 3'd3;

    localparam logic [1:0] ST_PASS    = 2'd0;
    localparam logic [1:0] ST_DONE    = 2'd1;
    localparam logic [1:0] ST_BADMETH = 2'd2;
    localparam logic [1:0] ST_TRUNC   = 2'd3;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    typedef enum logic [3:0] {
        M_HEAD  = 4'b0001,
        M_PASS  = 4'b0010,
        M_DRAIN = 4'b0100,
        M_GZIP  = 4'b1000
    } t_mode;

    typedef enum logic [6:0] {
        P_XLEN0   = 7'b0000001,
        P_XLEN1   = 7'b0000010,
        P_XSKIP   = 7'b0000100,
        P_NAME    = 7'b0001000,
        P_COMMENT = 7'b0010000,
        P_HCRC    = 7'b0100000,
        P_BODY    = 7'b1000000
    } t_pph;

    typedef enum logic [3:0] {
        B_IDLE   = 4'b0001,
        B_REPLAY = 4'b0010,
        B_DATA   = 4'b0100,
        B_END    = 4'b1000
    } t_bstate;

    // at most one command per accepted word; the back end acts on hold, replay, data, end in that order
    typedef struct packed {
        logic             hold;
        logic [IDX_W-1:0] idx;
        logic [IDX_W-1:0] rep_n;
        logic             data_v;
        logic             end_v;
        logic [1:0]       status;
        logic [7:0]       data;
    } t_cmd;

    function automatic t_pph f_enter(input logic [2:0] stage, input logic [4:0] flags);
        t_pph r;
        r = P_BODY;
        if (stage <= STG_HCRC && flags[FLG_HCRC])       r = P_HCRC;
        if (stage <= STG_COMMENT && flags[FLG_COMMENT]) r = P_COMMENT;
        if (stage <= STG_NAME && flags[FLG_NAME])       r = P_NAME;
        if (stage <= STG_EXTRA && flags[FLG_EXTRA])     r = P_XLEN0;
        return r;
    endfunction

endpackage

// ===== rtl/ghd_front.sv =====
// Front end: accepts words, tracks the header, trailer delay, issues commands.
module ghd_front import ghd_pkg::*; #(
    parameter int COUNT_BITS = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_in_byte,
    input  logic       i_is_last,
    input  logic       i_full,
    output logic       o_stall,
    output logic       o_push,
    output t_cmd       o_cmd
);

    t_mode                  r_mode, n_mode;
    t_pph                   r_pph;
    logic [COUNT_BITS-1:0]  r_cnt;
    logic [4:0]             r_flags;
    logic                   r_meth_ok;
    logic [15:0]            r_skip;
    logic [FILL_W-1:0]      r_fill;
    logic [7:0]             r_tdly [TRAILER_LEN];

    logic              w_acc, w_mis, w_upd;
    logic [IDX_W-1:0]  w_idx;
    t_pph              w_pcur, f_pph;
    logic [15:0]       w_scur, f_skip, w_dec, w_xl;
    logic              f_emit, f_shift;
    logic [FILL_W-1:0] f_fill;
    logic [1:0]        w_status;
    t_cmd              w_cmd;

    assign w_acc   = i_valid && !i_full;
    assign o_stall = i_full;

    assign w_idx = (r_cnt < COUNT_BITS'(HEAD_LEN)) ? r_cnt[IDX_W-1:0] : IDX_W'(HEAD_LEN - 1);
    assign w_mis = (w_idx == IDX_W'(0) && i_in_byte != MAGIC0) ||
                   (w_idx == IDX_W'(1) && i_in_byte != MAGIC1);

    // first byte after the 10-byte fixed header starts the field parse
    assign w_pcur = (r_mode == M_HEAD && w_idx == IDX_W'(FIXED_LEN)) ?
                    f_enter(STG_EXTRA, r_flags) : r_pph;
    assign w_scur = (r_mode == M_HEAD && w_idx == IDX_W'(FIXED_LEN)) ? 16'd2 : r_skip;
    assign w_dec  = w_scur - 16'd1;
    assign w_xl   = {i_in_byte, w_scur[7:0]};

    always_comb begin
        f_pph   = w_pcur;
        f_skip  = w_scur;
        f_emit  = 1'b0;
        f_shift = 1'b0;
        unique case (w_pcur)
            P_XLEN0: begin
                f_skip = {8'd0, i_in_byte};
                f_pph  = P_XLEN1;
            end
            P_XLEN1: begin
                f_skip = w_xl;
                if (w_xl == 16'd0) begin
                    f_pph  = f_enter(STG_NAME, r_flags);
                    f_skip = 16'd2;
                end else begin
                    f_pph = P_XSKIP;
                end
            end
            P_XSKIP: begin
                f_skip = w_dec;
                if (w_dec == 16'd0) begin
                    f_pph  = f_enter(STG_NAME, r_flags);
                    f_skip = 16'd2;
                end
            end
            P_NAME: begin
                if (i_in_byte == 8'd0) begin
                    f_pph  = f_enter(STG_COMMENT, r_flags);
                    f_skip = 16'd2;
                end
            end
            P_COMMENT: begin
                if (i_in_byte == 8'd0) begin
                    f_pph  = f_enter(STG_HCRC, r_flags);
                    f_skip = 16'd2;
                end
            end
            P_HCRC: begin
                f_skip = w_dec;
                if (w_dec == 16'd0) f_pph = P_BODY;
            end
            P_BODY: begin
                f_shift = 1'b1;
                f_emit  = (r_fill == FILL_W'(TRAILER_LEN));
            end
            default: ;
        endcase
    end

    assign f_fill = (f_shift && r_fill != FILL_W'(TRAILER_LEN)) ? r_fill + FILL_W'(1) : r_fill;

    always_comb begin
        n_mode       = r_mode;
        w_upd        = 1'b0;
        w_cmd        = '0;
        w_cmd.idx    = w_idx;
        w_cmd.data   = i_in_byte;
        unique case (r_mode)
            M_HEAD: begin
                w_cmd.hold = 1'b1;
                if (w_mis) begin
                    w_cmd.rep_n = w_idx + IDX_W'(1);
                    n_mode      = M_PASS;
                end else if (w_idx == IDX_W'(HEAD_LEN - 1)) begin
                    if (r_meth_ok) begin
                        n_mode = M_GZIP;
                        w_upd  = 1'b1;
                    end else begin
                        n_mode = M_DRAIN;
                    end
                end else begin
                    if (i_is_last) w_cmd.rep_n = w_idx + IDX_W'(1);
                    if (w_idx >= IDX_W'(FIXED_LEN)) w_upd = 1'b1;
                end
            end
            M_PASS: w_cmd.data_v = 1'b1;
            M_DRAIN: ;
            M_GZIP: begin
                w_upd        = 1'b1;
                w_cmd.data_v = f_emit;
                w_cmd.data   = r_tdly[TRAILER_LEN-1];
            end
            default: ;
        endcase

        case (n_mode)
            M_GZIP:  w_status = (f_pph == P_BODY && f_fill == FILL_W'(TRAILER_LEN)) ?
                                ST_DONE : ST_TRUNC;
            M_DRAIN: w_status = ST_BADMETH;
            default: w_status = ST_PASS;
        endcase
        w_cmd.end_v  = i_is_last;
        w_cmd.status = w_status;
    end

    assign o_cmd  = w_cmd;
    assign o_push = w_acc && (w_cmd.hold || w_cmd.data_v || w_cmd.end_v);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= M_HEAD;
            r_pph     <= P_XLEN0;
            r_cnt     <= '0;
            r_flags   <= '0;
            r_meth_ok <= 1'b0;
            r_skip    <= '0;
            r_fill    <= '0;
        end else if (w_acc) begin
            if (i_is_last) begin
                r_mode    <= M_HEAD;
                r_cnt     <= '0;
                r_flags   <= '0;
                r_meth_ok <= 1'b0;
                r_skip    <= '0;
                r_fill    <= '0;
            end else begin
                r_mode <= n_mode;
                if (r_cnt != '1) r_cnt <= r_cnt + COUNT_BITS'(1);
                if (r_mode == M_HEAD && w_idx == IDX_W'(2))
                    r_meth_ok <= (i_in_byte == METHOD_DEFLATE);
                if (r_mode == M_HEAD && w_idx == IDX_W'(3))
                    r_flags <= i_in_byte[4:0];
                if (w_upd) begin
                    r_pph  <= f_pph;
                    r_skip <= f_skip;
                    r_fill <= f_fill;
                end
            end
        end
    end

    // trailer hold-back line, newest at entry 0
    always_ff @(posedge i_clk) begin
        if (w_acc && w_upd && f_shift) begin
            r_tdly[0] <= i_in_byte;
            for (int k = 1; k < TRAILER_LEN; k++) r_tdly[k] <= r_tdly[k-1];
        end
    end

endmodule

// ===== rtl/ghd_queue.sv =====
// Command queue between front end and back end.
module ghd_queue import ghd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_empty,
    output logic o_full
);

    t_cmd                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr, r_rd;
    logic [QUEUE_AW:0]   r_cnt;

    assign o_cmd   = r_mem[r_rd];
    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == (QUEUE_AW+1)'(QUEUE_DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + QUEUE_AW'(1);
            if (i_pop)  r_rd <= r_rd + QUEUE_AW'(1);
            if (i_push && !i_pop)      r_cnt <= r_cnt + (QUEUE_AW+1)'(1);
            else if (!i_push && i_pop) r_cnt <= r_cnt - (QUEUE_AW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_cmd;
    end

endmodule

// ===== rtl/ghd_back.sv =====
// Back end: holds the head bytes, runs replays and drives the output register.
module ghd_back import ghd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_empty,
    input  t_cmd       i_cmd,
    output logic       o_pop,
    input  logic       i_stall,
    output logic       o_valid,
    output logic       o_kind,
    output logic [7:0] o_out_byte,
    output logic [1:0] o_status,
    output logic       o_last
);

    t_bstate          r_st, w_after, w_first;
    t_cmd             r_cmd;
    logic [IDX_W-1:0] r_k;
    logic [7:0]       r_head [HEAD_LEN];
    logic             r_ov;
    logic             r_kind, r_last;
    logic [7:0]       r_byte;
    logic [1:0]       r_status;

    logic w_slot, w_emit, w_rep_end, w_free;

    assign w_slot    = !r_ov || !i_stall;
    assign w_emit    = (r_st != B_IDLE) && w_slot;
    assign w_rep_end = (r_k == r_cmd.rep_n - IDX_W'(1));

    always_comb begin
        w_after = B_IDLE;
        unique case (r_st)
            B_REPLAY: begin
                if (!w_rep_end)        w_after = B_REPLAY;
                else if (r_cmd.data_v) w_after = B_DATA;
                else if (r_cmd.end_v)  w_after = B_END;
                else                   w_after = B_IDLE;
            end
            B_DATA:  w_after = r_cmd.end_v ? B_END : B_IDLE;
            B_END:   w_after = B_IDLE;
            B_IDLE:  w_after = B_IDLE;
            default: w_after = B_IDLE;
        endcase
    end

    always_comb begin
        if (i_cmd.rep_n != '0) w_first = B_REPLAY;
        else if (i_cmd.data_v) w_first = B_DATA;
        else if (i_cmd.end_v)  w_first = B_END;
        else                   w_first = B_IDLE;
    end

    assign w_free = (r_st == B_IDLE) || (w_emit && w_after == B_IDLE);
    assign o_pop  = w_free && !i_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= B_IDLE;
            r_ov <= 1'b0;
        end else begin
            if (o_pop)       r_st <= w_first;
            else if (w_emit) r_st <= w_after;
            if (w_emit)        r_ov <= 1'b1;
            else if (!i_stall) r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_cmd;
            r_k   <= '0;
        end else if (w_emit && r_st == B_REPLAY && !w_rep_end) begin
            r_k <= r_k + IDX_W'(1);
        end
        if (o_pop && i_cmd.hold) r_head[i_cmd.idx] <= i_cmd.data;
        if (w_emit) begin
            case (r_st)
                B_REPLAY: begin
                    r_kind   <= KIND_DATA;
                    r_byte   <= r_head[r_k];
                    r_status <= ST_PASS;
                    r_last   <= 1'b0;
                end
                B_DATA: begin
                    r_kind   <= KIND_DATA;
                    r_byte   <= r_cmd.data;
                    r_status <= ST_PASS;
                    r_last   <= 1'b0;
                end
                default: begin
                    r_kind   <= KIND_END;
                    r_byte   <= 8'd0;
                    r_status <= r_cmd.status;
                    r_last   <= 1'b1;
                end
            endcase
        end
    end

    assign o_valid    = r_ov;
    assign o_kind     = r_kind;
    assign o_out_byte = r_byte;
    assign o_status   = r_status;
    assign o_last     = r_last;

endmodule

// ===== rtl/gzip_header_deframer_top.sv =====
// Top level of the gzip header deframer: front end, command queue, back end.
// A word that yields output passes the command queue and the back-end command register first.
// Throughput: one input word per cycle while the queue has room; the back end emits one
// output word per cycle while the output is not stalled, so a header replay of n held bytes
// occupies it for n output words and the input stalls once the four-entry queue fills behind it.
// Reset: synchronous, active low; clears stream state, queue and output valid, no sweep.
module gzip_header_deframer_top import ghd_pkg::*; #(
    parameter int COUNT_BITS = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_is_last,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_kind,
    output logic [7:0] o_out_byte,
    output logic [1:0] o_status,
    output logic       o_last
);

    t_cmd w_push_cmd, w_head_cmd;
    logic w_push, w_pop, w_empty, w_full;

    ghd_front #(.COUNT_BITS(COUNT_BITS)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .i_in_byte (i_in_byte),
        .i_is_last (i_is_last),
        .i_full    (w_full),
        .o_stall   (o_in_stall),
        .o_push    (w_push),
        .o_cmd     (w_push_cmd)
    );

    ghd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .i_pop   (w_pop),
        .o_cmd   (w_head_cmd),
        .o_empty (w_empty),
        .o_full  (w_full)
    );

    ghd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (w_empty),
        .i_cmd      (w_head_cmd),
        .o_pop      (w_pop),
        .i_stall    (i_out_stall),
        .o_valid    (o_out_valid),
        .o_kind     (o_kind),
        .o_out_byte (o_out_byte),
        .o_status   (o_status),
        .o_last     (o_last)
    );

endmodule

// ===== rtl/ghd_checker.sv =====
// Port-level checks for the gzip header deframer, bound to the top level.
module ghd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic       o_kind,
    input logic [7:0] o_out_byte,
    input logic [1:0] o_status,
    input logic       o_last
);

    a_rst_out: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output word valid right after reset");

    a_rst_stall: assert property (@(posedge i_clk) !i_rst_n |=> !o_in_stall)
        else $error("input stalled right after reset");

    a_stall_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_in_stall) |-> $past(i_in_valid && !o_in_stall))
        else $error("input stall rose without a word accepted");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_kind) &&
        $stable(o_out_byte) && $stable(o_status) && $stable(o_last))
        else $error("stalled output word changed");

endmodule

bind gzip_header_deframer_top ghd_checker u_chk (.*);

// ===== tb/sv/gzip_deframe_checker.sv =====
// Watches both channels of the gzip header deframer, predicts each output word and compares.
module gzip_deframe_checker import ghd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_is_last,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  logic       i_kind,
    input  logic [7:0] i_out_byte,
    input  logic [1:0] i_status,
    input  logic       i_last,
    output int         o_errors,
    output int         o_pending
);

    typedef enum logic [9:0] {
        S_HOLD     = 10'b0000000001,
        S_THRU     = 10'b0000000010,
        S_SWALLOW  = 10'b0000000100,
        S_XLEN_LO  = 10'b0000001000,
        S_XLEN_HI  = 10'b0000010000,
        S_XDATA    = 10'b0000100000,
        S_FNAME    = 10'b0001000000,
        S_FCOMMENT = 10'b0010000000,
        S_FHCRC    = 10'b0100000000,
        S_DEFLATE  = 10'b1000000000
    } t_parse;

    typedef enum logic [1:0] {D_OPEN, D_THRU, D_GZIP, D_BADMETH} t_decision;

    typedef struct packed {
        logic       kind;
        logic [7:0] data;
        logic [1:0] status;
        logic       last;
    } t_out_word;

    localparam logic [2:0] STG_DEFLATE = 3'd4;

    t_out_word   due_words [$];
    logic [7:0]  head_bytes [HEAD_LEN];
    logic [7:0]  tail_ring [TRAILER_LEN];
    logic [31:0] stream_pos;
    t_parse      parse_st;
    t_decision   decision;
    logic [4:0]  flags;
    logic [15:0] skip_cnt;
    logic [3:0]  tail_fill;
    logic [2:0]  tail_wr;
    int          err_cnt = 0;

    function automatic void queue_word(logic k, logic [7:0] d, logic [1:0] s, logic l);
        t_out_word w;
        w.kind   = k;
        w.data   = d;
        w.status = s;
        w.last   = l;
        due_words.push_back(w);
    endfunction

    function automatic void clear_stream();
        stream_pos = '0;
        parse_st   = S_HOLD;
        decision   = D_OPEN;
        flags      = '0;
        skip_cnt   = '0;
        tail_fill  = '0;
        tail_wr    = '0;
    endfunction

    function automatic void replay_head(int upto);
        for (int k = 0; k <= upto; k++) queue_word(KIND_DATA, head_bytes[k], ST_PASS, 1'b0);
    endfunction

    // pick the first header field present at or after the given stage
    function automatic void next_field(logic [2:0] stg);
        if (stg <= STG_EXTRA && flags[FLG_EXTRA]) begin
            parse_st = S_XLEN_LO;
        end else if (stg <= STG_NAME && flags[FLG_NAME]) begin
            parse_st = S_FNAME;
        end else if (stg <= STG_COMMENT && flags[FLG_COMMENT]) begin
            parse_st = S_FCOMMENT;
        end else if (stg <= STG_HCRC && flags[FLG_HCRC]) begin
            parse_st = S_FHCRC;
            skip_cnt = 16'd2;
        end else begin
            parse_st = S_DEFLATE;
        end
    endfunction

    function automatic void take_field_byte(logic [7:0] b);
        case (parse_st)
            S_XLEN_LO: begin
                skip_cnt = {8'h00, b};
                parse_st = S_XLEN_HI;
            end
            S_XLEN_HI: begin
                skip_cnt[15:8] = b;
                if (skip_cnt == 16'd0) next_field(STG_NAME);
                else parse_st = S_XDATA;
            end
            S_XDATA: begin
                skip_cnt = skip_cnt - 16'd1;
                if (skip_cnt == 16'd0) next_field(STG_NAME);
            end
            S_FNAME: begin
                if (b == 8'h00) next_field(STG_COMMENT);
            end
            S_FCOMMENT: begin
                if (b == 8'h00) next_field(STG_HCRC);
            end
            S_FHCRC: begin
                skip_cnt = skip_cnt - 16'd1;
                if (skip_cnt == 16'd0) next_field(STG_DEFLATE);
            end
            S_DEFLATE: begin
                // the last eight body bytes are the trailer and never leave
                if (tail_fill >= TRAILER_LEN)
                    queue_word(KIND_DATA, tail_ring[tail_wr], ST_PASS, 1'b0);
                tail_ring[tail_wr] = b;
                tail_wr = tail_wr + 3'd1;
                if (tail_fill < TRAILER_LEN) tail_fill = tail_fill + 4'd1;
            end
            default: ;
        endcase
    endfunction

    function automatic void predict_word(logic [7:0] b, logic lst);
        int         idx;
        logic [1:0] st_code;
        if (parse_st == S_HOLD) begin
            idx = (stream_pos < HEAD_LEN) ? int'(stream_pos) : HEAD_LEN - 1;
            head_bytes[idx] = b;
            if ((idx == 0 && b != MAGIC0) || (idx == 1 && b != MAGIC1)) begin
                replay_head(idx);
                parse_st = S_THRU;
                decision = D_THRU;
            end else if (idx == HEAD_LEN - 1) begin
                if (head_bytes[2] != METHOD_DEFLATE) begin
                    decision = D_BADMETH;
                    parse_st = S_SWALLOW;
                end else begin
                    decision = D_GZIP;
                    flags = head_bytes[3][4:0];
                    next_field(STG_EXTRA);
                    for (int k = FIXED_LEN; k < HEAD_LEN; k++) take_field_byte(head_bytes[k]);
                end
            end else if (lst) begin
                replay_head(idx);
                decision = D_THRU;
            end
        end else if (parse_st == S_THRU) begin
            queue_word(KIND_DATA, b, ST_PASS, 1'b0);
        end else if (parse_st != S_SWALLOW) begin
            take_field_byte(b);
        end

        if (stream_pos != '1) stream_pos = stream_pos + 32'd1;

        if (lst) begin
            if (decision == D_BADMETH)
                st_code = ST_BADMETH;
            else if (decision == D_GZIP)
                st_code = (parse_st == S_DEFLATE && tail_fill >= TRAILER_LEN) ? ST_DONE : ST_TRUNC;
            else
                st_code = ST_PASS;
            queue_word(KIND_END, 8'h00, st_code, 1'b1);
            clear_stream();
        end
    endfunction

    function automatic void check_word();
        t_out_word w;
        if (due_words.size() == 0) begin
            err_cnt++;
            if (err_cnt <= 10)
                $display("%0t: unexpected word kind=%0d byte=%02h status=%0d last=%0d",
                         $time, i_kind, i_out_byte, i_status, i_last);
        end else begin
            w = due_words.pop_front();
            if (w.kind != i_kind || w.data != i_out_byte || w.status != i_status
                || w.last != i_last) begin
                err_cnt++;
                if (err_cnt <= 10) begin
                    $display("%0t: mismatch exp kind=%0d byte=%02h status=%0d last=%0d",
                             $time, w.kind, w.data, w.status, w.last);
                    $display("%0t:          got kind=%0d byte=%02h status=%0d last=%0d",
                             $time, i_kind, i_out_byte, i_status, i_last);
                end
            end
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            due_words.delete();
            clear_stream();
        end else begin
            if (i_out_valid && !i_out_stall) check_word();
            if (i_in_valid && !i_in_stall) predict_word(i_in_byte, i_is_last);
        end
        o_errors  <= err_cnt;
        o_pending <= due_words.size();
    end

endmodule

// ===== tb/sv/tb.sv =====
// Testbench top for the gzip header deframer: clock, reset, byte stream stimulus and verdict.
module tb import ghd_pkg::*; ();

    logic       i_clk;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic [7:0] i_in_byte   = 8'h00;
    logic       i_is_last   = 1'b0;
    logic       i_out_stall = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    logic       o_kind;
    logic [7:0] o_out_byte;
    logic [1:0] o_status;
    logic       o_last;

    int fail_count;
    int pending_words;
    int in_idle_pct  = 33;
    int out_idle_pct = 50;
    int sent_words   = 0;

    logic [7:0] frame [$];

    gzip_header_deframer_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_byte   (i_in_byte),
        .i_is_last   (i_is_last),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_kind      (o_kind),
        .o_out_byte  (o_out_byte),
        .o_status    (o_status),
        .o_last      (o_last)
    );

    gzip_deframe_checker u_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_stall  (o_in_stall),
        .i_in_byte   (i_in_byte),
        .i_is_last   (i_is_last),
        .i_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_kind      (o_kind),
        .i_out_byte  (o_out_byte),
        .i_status    (o_status),
        .i_last      (o_last),
        .o_errors    (fail_count),
        .o_pending   (pending_words)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) i_out_stall <= ($urandom_range(99) < out_idle_pct);

    task automatic send_word(input logic [7:0] b, input logic lst);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_byte  <= b;
        i_is_last  <= lst;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic send_frame();
        for (int k = 0; k < frame.size(); k++) send_word(frame[k], k == frame.size() - 1);
        sent_words += frame.size();
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_words != 0) @(posedge i_clk);
    endtask

    task automatic push_random(input int n);
        repeat (n) frame.push_back(8'($urandom_range(255)));
    endtask

    // gzip member with random FLG; a long FEXTRA is cut off inside its data
    task automatic build_member(input logic long_extra);
        logic [7:0] flg;
        int         xlen;
        flg = 8'($urandom_range(255));
        if (long_extra) flg[FLG_EXTRA] = 1'b1;
        frame.delete();
        frame.push_back(MAGIC0);
        frame.push_back(MAGIC1);
        frame.push_back(METHOD_DEFLATE);
        frame.push_back(flg);
        push_random(6);
        if (flg[FLG_EXTRA]) begin
            xlen = long_extra ? int'($urandom_range(16'hffff, 16'h0100)) : int'($urandom_range(6));
            frame.push_back(xlen[7:0]);
            frame.push_back(xlen[15:8]);
            if (long_extra) begin
                push_random($urandom_range(20, 8));
                return;
            end
            push_random(xlen);
        end
        if (flg[FLG_NAME]) begin
            repeat ($urandom_range(4)) frame.push_back(8'($urandom_range(255, 1)));
            frame.push_back(8'h00);
        end
        if (flg[FLG_COMMENT]) begin
            repeat ($urandom_range(4)) frame.push_back(8'($urandom_range(255, 1)));
            frame.push_back(8'h00);
        end
        if (flg[FLG_HCRC]) push_random(2);
        push_random($urandom_range(8) + TRAILER_LEN);
    endtask

    task automatic build_foreign();
        logic [7:0] b;
        frame.delete();
        b = 8'($urandom_range(255));
        if ($urandom_range(1)) begin
            frame.push_back((b == MAGIC0) ? ~MAGIC0 : b);
        end else begin
            frame.push_back(MAGIC0);
            frame.push_back((b == MAGIC1) ? ~MAGIC1 : b);
        end
        push_random($urandom_range(10));
    endtask

    task automatic build_short();
        int len;
        len = $urandom_range(HEAD_LEN - 1, 1);
        frame.delete();
        frame.push_back(MAGIC0);
        if (len > 1) frame.push_back(MAGIC1);
        push_random(len - frame.size());
    endtask

    initial begin
        int pick;
        int cut;
        int guard;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // wrong first byte, extremes
        frame.delete();
        frame.push_back(8'h00);
        send_frame();
        frame.delete();
        frame.push_back(8'hff);
        send_frame();
        // stream ends inside the held header
        frame.delete();
        frame.push_back(MAGIC0);
        send_frame();
        // wrong second byte
        frame.delete();
        frame.push_back(MAGIC0);
        frame.push_back(8'h00);
        frame.push_back(8'hff);
        send_frame();
        // bare header plus trailer: empty body
        frame.delete();
        frame.push_back(MAGIC0);
        frame.push_back(MAGIC1);
        frame.push_back(METHOD_DEFLATE);
        repeat (7) frame.push_back(8'h00);
        repeat (TRAILER_LEN) frame.push_back(8'hff);
        send_frame();

        wait_drained();

        while (sent_words < 310) begin
            if (sent_words < 120) begin
                in_idle_pct  = 33;
                out_idle_pct = 50;
            end else if (sent_words < 220) begin
                in_idle_pct  = 50;
                out_idle_pct = 33;
            end else begin
                in_idle_pct  = 0;
                out_idle_pct = 0;
            end
            pick = $urandom_range(99);
            if (pick < 55) begin
                build_member(1'b0);
            end else if (pick < 67) begin
                build_member(1'b0);
                cut = $urandom_range(frame.size() - 1, 1);
                while (frame.size() > cut) void'(frame.pop_back());
            end else if (pick < 72) begin
                build_member(1'b1);
            end else if (pick < 82) begin
                build_member(1'b0);
                frame[2] = METHOD_DEFLATE ^ 8'($urandom_range(255, 1));
            end else if (pick < 91) begin
                build_foreign();
            end else begin
                build_short();
            end
            send_frame();
        end

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        guard = 0;
        while (pending_words != 0 && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && pending_words == 0)
            $display("gzip_header_deframer_top verification clean");
        else
            $display("gzip_header_deframer_top verification failed");
        $finish;
    end

    initial begin
        #(12 * 300000);
        $display("gzip_header_deframer_top verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/ghd_pkg.sv
rtl/ghd_front.sv
rtl/ghd_queue.sv
rtl/ghd_back.sv
rtl/gzip_header_deframer_top.sv
rtl/ghd_checker.sv
tb/sv/gzip_deframe_checker.sv
tb/sv/tb.sv
